// File: hw/rtl/i2cbb_pkg.sv
// Shared types and constants for the I2C bit-bang master.
// This package has no dependencies. The front, the engine and the top level import it.
`timescale 1ns / 1ps
`default_nettype none

package i2cbb_pkg;

  // These are the command codes that the kind field carries.
  typedef enum logic [2:0] {
    CMD_IDLE  = 3'd0,
    CMD_START = 3'd1,
    CMD_STOP  = 3'd2,
    CMD_SEND  = 3'd3,
    CMD_WACK  = 3'd4,
    CMD_READ  = 3'd5,
    CMD_ACK   = 3'd6,
    CMD_NACK  = 3'd7
  } cmd_e;

  // This is the configuration register map.
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_DATA_W = 16;
  localparam logic [CFG_IDX_W-1:0] CFG_HALF_PERIOD = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ACK_LIMIT   = 2'd1;

  localparam logic [15:0] HALF_PERIOD_RST = 16'd160;
  localparam logic [7:0]  ACK_LIMIT_RST   = 8'd250;

  // This is the default depth of the tick queue between the front and the engine.
  localparam int unsigned FIFO_DEPTH = 2;

  // One classified tick, as it is queued for the engine.
  typedef struct packed {
    cmd_e       cmd;
    logic [7:0] tx_byte;
    logic       ack_sel;
    logic       sda;
  } tick_t;

  // This is the handshake from the queue to the engine.
  typedef struct packed {
    logic  valid;
    tick_t tick;
  } tick_req_t;

endpackage

`default_nettype wire

// File: hw/rtl/i2cbb_front.sv
// Front part of the I2C master: it accepts ticks, decodes the command and queues them.
// It depends on i2cbb_pkg.
`timescale 1ns / 1ps
`default_nettype none

module i2cbb_front import i2cbb_pkg::*; #(
  parameter int unsigned Depth = FIFO_DEPTH
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_ready_o,
  input  wire logic [2:0] kind_i,
  input  wire logic [7:0] tx_byte_i,
  input  wire logic       ack_after_read_i,
  input  wire logic       sda_in_i,
  output tick_req_t       req_o,
  input  wire logic       pop_i
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  tick_t            store_q [Depth];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  count_q, count_d;
  logic             push;
  tick_t            tick_in;

  assign in_ready_o = (count_q != CntW'(Depth));
  assign push       = in_valid_i && in_ready_o;

  always_comb begin
    tick_in.cmd     = cmd_e'(kind_i);
    tick_in.tx_byte = tx_byte_i;
    tick_in.ack_sel = ack_after_read_i;
    tick_in.sda     = sda_in_i;
  end

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (pop_i && !push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      store_q[wr_ptr_q] <= tick_in;
    end
  end

  assign req_o.valid = (count_q != '0);
  assign req_o.tick  = store_q[rd_ptr_q];

  // The queue must never overfill, and it must never be popped while it is empty.
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(Depth))
    else $error("tick queue overfilled");
  a_pop_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> count_q != '0)
    else $error("tick queue popped while empty");

endmodule

`default_nettype wire

// File: hw/rtl/i2cbb_engine.sv
// Back part of the I2C master: the bus sequencer, which advances one tick per popped entry.
// It also holds the result register. It depends on i2cbb_pkg.
`timescale 1ns / 1ps
`default_nettype none

module i2cbb_engine import i2cbb_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire tick_req_t   req_i,
  output logic             pop_o,
  input  wire logic [15:0] half_period_i,
  input  wire logic [7:0]  ack_limit_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic             scl_out_o,
  output logic             sda_release_o,
  output logic             busy_res_o,
  output logic             done_res_o,
  output logic [7:0]       rx_byte_o,
  output logic             ack_error_o
);

  typedef enum logic [1:0] {
    PH_A = 2'd0,
    PH_B = 2'd1,
    PH_C = 2'd2,
    PH_D = 2'd3
  } phase_e;

  cmd_e        cmd_q, cmd_d;
  phase_e      phase_q, phase_d;
  logic [3:0]  bit_idx_q, bit_idx_d;
  logic [7:0]  shift_q, shift_d;
  logic [15:0] timer_q, timer_d;
  logic [7:0]  ack_cnt_q, ack_cnt_d;
  logic        scl_q, scl_d;
  logic        sda_q, sda_d;
  logic [7:0]  rx_q, rx_d;
  logic        err_q, err_d;
  logic        rack_q, rack_d;
  logic        done_d;
  logic        run;
  logic        out_valid_q;
  tick_t       t;

  assign t     = req_i.tick;
  assign pop_o = req_i.valid && (!out_valid_q || out_ready_i);

  always_comb begin
    cmd_d     = cmd_q;
    phase_d   = phase_q;
    bit_idx_d = bit_idx_q;
    shift_d   = shift_q;
    timer_d   = timer_q;
    ack_cnt_d = ack_cnt_q;
    scl_d     = scl_q;
    sda_d     = sda_q;
    rx_d      = rx_q;
    err_d     = err_q;
    rack_d    = rack_q;
    done_d    = 1'b0;
    run       = 1'b0;

    // An idle engine launches the command, if one is present. A busy engine
    // counts down the current step or runs its next phase.
    if (cmd_q == CMD_IDLE) begin
      if (t.cmd != CMD_IDLE) begin
        cmd_d     = t.cmd;
        phase_d   = PH_A;
        bit_idx_d = '0;
        timer_d   = '0;
        run       = 1'b1;
        if (t.cmd == CMD_SEND) begin
          shift_d = t.tx_byte;
        end
        if (t.cmd == CMD_READ) begin
          shift_d = '0;
          sda_d   = 1'b1;
          rack_d  = t.ack_sel;
        end
        if (t.cmd == CMD_WACK) begin
          ack_cnt_d = '0;
          err_d     = 1'b0;
        end
      end
    end else if (timer_q > 16'd1) begin
      timer_d = timer_q - 16'd1;
    end else begin
      run = 1'b1;
    end

    if (run) begin
      case (cmd_d)
        CMD_START: begin
          case (phase_d)
            PH_A: begin
              sda_d = 1'b1; scl_d = 1'b1;
              phase_d = PH_B; timer_d = half_period_i;
            end
            PH_B: begin
              sda_d = 1'b0;
              phase_d = PH_C; timer_d = half_period_i;
            end
            default: begin
              scl_d = 1'b0;
              cmd_d = CMD_IDLE; phase_d = PH_A; timer_d = '0; done_d = 1'b1;
            end
          endcase
        end
        CMD_STOP: begin
          case (phase_d)
            PH_A: begin
              scl_d = 1'b0; sda_d = 1'b0;
              phase_d = PH_B; timer_d = half_period_i;
            end
            PH_B: begin
              scl_d = 1'b1;
              phase_d = PH_C; timer_d = half_period_i;
            end
            PH_C: begin
              sda_d = 1'b1;
              phase_d = PH_D; timer_d = half_period_i;
            end
            default: begin
              cmd_d = CMD_IDLE; phase_d = PH_A; timer_d = '0; done_d = 1'b1;
            end
          endcase
        end
        CMD_SEND: begin
          case (phase_d)
            PH_B: begin
              scl_d = 1'b1;
              phase_d = PH_C; timer_d = half_period_i;
            end
            PH_C: begin
              scl_d = 1'b0;
              phase_d = PH_D; timer_d = half_period_i;
            end
            PH_D: begin
              // This is the end of one bit. Either finish, or put the next bit on SDA in the same tick.
              bit_idx_d = bit_idx_q + 4'd1;
              if (bit_idx_d >= 4'd8) begin
                cmd_d = CMD_IDLE; phase_d = PH_A; timer_d = '0; done_d = 1'b1;
              end else begin
                scl_d = 1'b0; sda_d = shift_q[7]; shift_d = {shift_q[6:0], 1'b0};
                phase_d = PH_B; timer_d = half_period_i;
              end
            end
            default: begin
              scl_d = 1'b0; sda_d = shift_d[7]; shift_d = {shift_d[6:0], 1'b0};
              phase_d = PH_B; timer_d = half_period_i;
            end
          endcase
        end
        CMD_WACK: begin
          case (phase_d)
            PH_A: begin
              sda_d = 1'b1;
              phase_d = PH_B; timer_d = half_period_i;
            end
            PH_B: begin
              scl_d = 1'b1;
              phase_d = PH_C; timer_d = half_period_i;
            end
            default: begin
              // The engine polls SDA every tick until the slave pulls it low or the limit runs out.
              timer_d = '0;
              if (!t.sda) begin
                scl_d = 1'b0;
                cmd_d = CMD_IDLE; phase_d = PH_A; done_d = 1'b1;
              end else if (ack_cnt_q >= ack_limit_i) begin
                // On a timeout, the engine flags the error and starts a stop sequence at once.
                err_d = 1'b1;
                cmd_d = CMD_STOP;
                scl_d = 1'b0; sda_d = 1'b0;
                phase_d = PH_B; timer_d = half_period_i;
              end else begin
                ack_cnt_d = ack_cnt_q + 8'd1;
              end
            end
          endcase
        end
        CMD_READ: begin
          case (phase_d)
            PH_A: begin
              scl_d = 1'b0;
              phase_d = PH_B; timer_d = half_period_i;
            end
            PH_B: begin
              scl_d = 1'b1; shift_d = {shift_q[6:0], t.sda};
              phase_d = PH_C; timer_d = half_period_i;
            end
            default: begin
              bit_idx_d = bit_idx_q + 4'd1;
              scl_d = 1'b0;
              phase_d = PH_B; timer_d = half_period_i;
              if (bit_idx_d >= 4'd8) begin
                // After the eighth bit, the engine goes straight into the ack or nack bit.
                rx_d  = shift_q;
                cmd_d = rack_q ? CMD_ACK : CMD_NACK;
                sda_d = !rack_q;
              end
            end
          endcase
        end
        CMD_ACK, CMD_NACK: begin
          case (phase_d)
            PH_A: begin
              scl_d = 1'b0; sda_d = (cmd_d == CMD_NACK);
              phase_d = PH_B; timer_d = half_period_i;
            end
            PH_B: begin
              scl_d = 1'b1;
              phase_d = PH_C; timer_d = half_period_i;
            end
            default: begin
              scl_d = 1'b0;
              cmd_d = CMD_IDLE; phase_d = PH_A; timer_d = '0; done_d = 1'b1;
            end
          endcase
        end
        default: begin
          cmd_d = CMD_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cmd_q         <= CMD_IDLE;
      phase_q       <= PH_A;
      bit_idx_q     <= '0;
      shift_q       <= '0;
      timer_q       <= '0;
      ack_cnt_q     <= '0;
      scl_q         <= 1'b1;
      sda_q         <= 1'b1;
      rx_q          <= '0;
      err_q         <= 1'b0;
      rack_q        <= 1'b0;
      out_valid_q   <= 1'b0;
      scl_out_o     <= 1'b1;
      sda_release_o <= 1'b1;
      busy_res_o    <= 1'b0;
      done_res_o    <= 1'b0;
      rx_byte_o     <= '0;
      ack_error_o   <= 1'b0;
    end else begin
      if (pop_o) begin
        cmd_q         <= cmd_d;
        phase_q       <= phase_d;
        bit_idx_q     <= bit_idx_d;
        shift_q       <= shift_d;
        timer_q       <= timer_d;
        ack_cnt_q     <= ack_cnt_d;
        scl_q         <= scl_d;
        sda_q         <= sda_d;
        rx_q          <= rx_d;
        err_q         <= err_d;
        rack_q        <= rack_d;
        out_valid_q   <= 1'b1;
        scl_out_o     <= scl_d;
        sda_release_o <= sda_d;
        busy_res_o    <= (cmd_d != CMD_IDLE);
        done_res_o    <= done_d;
        rx_byte_o     <= rx_d;
        ack_error_o   <= err_d;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o = out_valid_q;

  a_idle_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_q == CMD_IDLE |-> (phase_q == PH_A && timer_q == '0))
    else $error("idle engine holds phase or timer");
  a_phase_d_use: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_q != CMD_STOP && cmd_q != CMD_SEND) |-> phase_q != PH_D)
    else $error("fourth phase reached by a short command");
  a_bit_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    bit_idx_q <= 4'd8)
    else $error("bit index past eight");
  a_countdown: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop_o && cmd_q != CMD_IDLE && timer_q > 16'd1) |=> timer_q == $past(timer_q) - 16'd1)
    else $error("step timer did not count down");

endmodule

`default_nettype wire

// File: hw/rtl/i2c_bit_bang_master.sv
// Top level of the I2C bit-bang master. It holds the configuration registers and connects the parts.
// It depends on i2cbb_pkg, i2cbb_front and i2cbb_engine.
//
// Usage: every input transfer is one timing tick of the bus engine. It carries the sampled
// SDA level and, optionally, a command (kind). The engine takes a command only while it is idle.
// Commands that arrive while it is busy, and kind zero, count only as ticks. Every
// tick produces exactly one output transfer. That transfer holds the pin levels after the tick
// (scl_out, sda_release), the busy and done flags, the last received byte and the
// ack timeout flag.
// The configuration channel writes half_period_ticks (index 0) or ack_wait_limit (index
// 1). Writes to other indexes are ignored. The channel is always ready. Write it only
// while the engine is idle and no ticks are in flight.
// Throughput is one tick per clock cycle while the receiver does not stall. The engine
// updates its state once per popped tick. An input transfer passes through two registers
// on its way to the output: the tick queue and then the result register.
// At reset, both pins are released, the engine is idle, and the queue and the result register are
// empty. The registers return to 160 and 250.
// When the receiver stalls, the result waits in the output register. Ticks keep filling
// the queue (FifoDepth entries) until it is full. Only then does in_ready_o fall.
`timescale 1ns / 1ps
`default_nettype none

module i2c_bit_bang_master import i2cbb_pkg::*; #(
  parameter int unsigned FifoDepth = FIFO_DEPTH
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  in_valid_i,
  output logic                       in_ready_o,
  input  wire logic [2:0]            kind_i,
  input  wire logic [7:0]            tx_byte_i,
  input  wire logic                  ack_after_read_i,
  input  wire logic                  sda_in_i,
  output logic                       out_valid_o,
  input  wire logic                  out_ready_i,
  output logic                       scl_out_o,
  output logic                       sda_release_o,
  output logic                       busy_res_o,
  output logic                       done_res_o,
  output logic [7:0]                 rx_byte_o,
  output logic                       ack_error_o,
  input  wire logic                  cfg_valid_i,
  output logic                       cfg_ready_o,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i
);

  logic [15:0] half_period_q;
  logic [7:0]  ack_limit_q;
  tick_req_t   req;
  logic        pop;

  // The configuration registers never back-pressure the channel.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      half_period_q <= HALF_PERIOD_RST;
      ack_limit_q   <= ACK_LIMIT_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        CFG_HALF_PERIOD: half_period_q <= cfg_data_i[15:0];
        CFG_ACK_LIMIT:   ack_limit_q   <= cfg_data_i[7:0];
        default:         ;
      endcase
    end
  end

  // The front accepts and decodes ticks into a short queue.
  i2cbb_front #(
    .Depth (FifoDepth)
  ) u_front (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .kind_i           (kind_i),
    .tx_byte_i        (tx_byte_i),
    .ack_after_read_i (ack_after_read_i),
    .sda_in_i         (sda_in_i),
    .req_o            (req),
    .pop_i            (pop)
  );

  // The engine advances the bus sequence once per popped tick. It pops only when the
  // result register is free or is being emptied.
  i2cbb_engine u_engine (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .req_i         (req),
    .pop_o         (pop),
    .half_period_i (half_period_q),
    .ack_limit_i   (ack_limit_q),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .scl_out_o     (scl_out_o),
    .sda_release_o (sda_release_o),
    .busy_res_o    (busy_res_o),
    .done_res_o    (done_res_o),
    .rx_byte_o     (rx_byte_o),
    .ack_error_o   (ack_error_o)
  );

endmodule

`default_nettype wire

// File: bench/tb_i2c_bit_bang_master.sv
`timescale 1ns / 1ps
// Self-checking testbench for the I2C bit-bang master top level (i2c_bit_bang_master).
// It depends on i2cbb_pkg for the command codes and the register map, and on the RTL alone.
// A bus predictor computes each expected pin state and the monitor checks every output transfer.

module tb_i2c_bit_bang_master;
  import i2cbb_pkg::*;

  // Indexes outside the register map. Writes to them must leave both registers alone.
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 2'd3;

  // The run fails if no transfer of any kind happens for this many cycles.
  localparam int unsigned QUIET_LIMIT = 4000;
  // This is how many ticks may wait in the pending queue before the generator pauses.
  localparam int unsigned QUEUE_CAP = 64;

  // These are the patterns for the sampled SDA level while a command runs.
  typedef enum logic [1:0] {
    SDA_NOISE,
    SDA_LOW,
    SDA_ACK_SOON,
    SDA_STUCK_HIGH
  } sda_style_e;

  typedef struct packed {
    cmd_e       kind;
    logic [7:0] tx;
    logic       ack_sel;
    logic       sda;
  } bus_tick_t;

  typedef struct packed {
    logic       scl;
    logic       sda_rel;
    logic       busy;
    logic       done;
    logic [7:0] rx;
    logic       err;
  } bus_state_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  logic                  in_valid = 1'b0;
  logic                  in_ready_o;
  logic [2:0]            kind_i = CMD_IDLE;
  logic [7:0]            tx_byte_i = 8'h00;
  logic                  ack_after_read_i = 1'b0;
  logic                  sda_in_i = 1'b1;
  logic                  out_valid_o;
  logic                  out_ready = 1'b1;
  logic                  scl_out_o;
  logic                  sda_release_o;
  logic                  busy_res_o;
  logic                  done_res_o;
  logic [7:0]            rx_byte_o;
  logic                  ack_error_o;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index = CFG_HALF_PERIOD;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  bus_tick_t  pending_ticks[$];
  bus_state_t expected_bus_states[$];

  int unsigned fault_count = 0;
  int unsigned commands_started = 0;
  int unsigned quiet_cycles = 0;
  int unsigned send_wait = 0;
  int unsigned send_calm = 0;
  int unsigned recv_wait = 0;
  int unsigned recv_calm = 0;
  bus_tick_t   next_tick;
  bus_state_t  want;

  // The predictor keeps its own copy of the engine state and of both registers.
  logic [15:0] half_period = HALF_PERIOD_RST;
  logic [7:0]  ack_limit = ACK_LIMIT_RST;
  cmd_e        eng_cmd = CMD_IDLE;
  logic [4:0]  eng_phase = '0;
  logic [3:0]  bits_done = '0;
  logic [7:0]  shifter = '0;
  logic [15:0] step_left = '0;
  logic [7:0]  poll_count = '0;
  logic        scl_lvl = 1'b1;
  logic        sda_lvl = 1'b1;
  logic [7:0]  rx_latched = '0;
  logic        timeout_flag = 1'b0;
  logic        read_acks = 1'b0;
  logic        done_flag = 1'b0;

  i2c_bit_bang_master dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid),
    .in_ready_o      (in_ready_o),
    .kind_i          (kind_i),
    .tx_byte_i       (tx_byte_i),
    .ack_after_read_i(ack_after_read_i),
    .sda_in_i        (sda_in_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready),
    .scl_out_o       (scl_out_o),
    .sda_release_o   (sda_release_o),
    .busy_res_o      (busy_res_o),
    .done_res_o      (done_res_o),
    .rx_byte_o       (rx_byte_o),
    .ack_error_o     (ack_error_o),
    .cfg_valid_i     (cfg_valid),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_index_i     (cfg_index),
    .cfg_data_i      (cfg_data)
  );

  always #6 clk_i = ~clk_i;

  // Gap lengths for both handshakes. Most gaps are zero or short, a few are long, and now
  // and then a calm stretch of back-to-back transfers starts.
  function automatic int unsigned pick_gap(inout int unsigned calm_left);
    int unsigned roll;
    if (calm_left > 0) begin
      calm_left--;
      return 0;
    end
    roll = $urandom_range(0, 99);
    if (roll < 2) begin
      calm_left = $urandom_range(40, 200);
      return 0;
    end
    if (roll < 65) return 0;
    if (roll < 96) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic pick_sda(input sda_style_e style);
    case (style)
      SDA_LOW:        return 1'b0;
      SDA_STUCK_HIGH: return 1'b1;
      SDA_ACK_SOON:   return ($urandom_range(0, 2) != 0);
      default:        return 1'($urandom_range(0, 1));
    endcase
  endfunction

  // Most acknowledge waits see the slave answer within a few polls; some never do, which
  // drives the engine into its timeout and the stop that follows it.
  function automatic sda_style_e pick_ack_style();
    int unsigned roll;
    roll = $urandom_range(0, 9);
    if (roll < 8) return SDA_ACK_SOON;
    if (roll < 9) return SDA_STUCK_HIGH;
    return SDA_NOISE;
  endfunction

  // A delay step ends: the next pin actions come half_period ticks from now.
  task automatic advance_phase();
    eng_phase++;
    step_left = half_period;
  endtask

  task automatic close_command();
    eng_cmd = CMD_IDLE;
    eng_phase = '0;
    step_left = '0;
    done_flag = 1'b1;
  endtask

  // Carries out the pin actions of the current phase. A send moving to its next bit, a read
  // moving to its next bit or to its ack, and a timed-out wait turning into a stop all act
  // again on the same tick.
  task automatic run_bus_phase(input logic sda);
    bit again;
    again = 1'b1;
    while (again) begin
      again = 1'b0;
      case (eng_cmd)
        CMD_START: begin
          if (eng_phase == 0) begin
            sda_lvl = 1'b1;
            scl_lvl = 1'b1;
            advance_phase();
          end else if (eng_phase == 1) begin
            sda_lvl = 1'b0;
            advance_phase();
          end else begin
            scl_lvl = 1'b0;
            close_command();
          end
        end
        CMD_STOP: begin
          if (eng_phase == 0) begin
            scl_lvl = 1'b0;
            sda_lvl = 1'b0;
            advance_phase();
          end else if (eng_phase == 1) begin
            scl_lvl = 1'b1;
            advance_phase();
          end else if (eng_phase == 2) begin
            sda_lvl = 1'b1;
            advance_phase();
          end else begin
            close_command();
          end
        end
        CMD_SEND: begin
          if (eng_phase == 0) begin
            scl_lvl = 1'b0;
            sda_lvl = shifter[7];
            shifter = {shifter[6:0], 1'b0};
            advance_phase();
          end else if (eng_phase == 1) begin
            scl_lvl = 1'b1;
            advance_phase();
          end else if (eng_phase == 2) begin
            scl_lvl = 1'b0;
            advance_phase();
          end else begin
            bits_done++;
            if (bits_done >= 8) begin
              close_command();
            end else begin
              eng_phase = '0;
              again = 1'b1;
            end
          end
        end
        CMD_WACK: begin
          if (eng_phase == 0) begin
            sda_lvl = 1'b1;
            advance_phase();
          end else if (eng_phase == 1) begin
            scl_lvl = 1'b1;
            advance_phase();
          end else begin
            // Polling: one look at SDA on every tick.
            step_left = '0;
            if (!sda) begin
              scl_lvl = 1'b0;
              close_command();
            end else if (poll_count >= ack_limit) begin
              timeout_flag = 1'b1;
              eng_cmd = CMD_STOP;
              eng_phase = '0;
              again = 1'b1;
            end else begin
              poll_count++;
            end
          end
        end
        CMD_READ: begin
          if (eng_phase == 0) begin
            scl_lvl = 1'b0;
            advance_phase();
          end else if (eng_phase == 1) begin
            scl_lvl = 1'b1;
            shifter = {shifter[6:0], sda};
            advance_phase();
          end else begin
            bits_done++;
            if (bits_done >= 8) begin
              rx_latched = shifter;
              eng_cmd = read_acks ? CMD_ACK : CMD_NACK;
            end
            eng_phase = '0;
            again = 1'b1;
          end
        end
        CMD_ACK, CMD_NACK: begin
          if (eng_phase == 0) begin
            scl_lvl = 1'b0;
            sda_lvl = (eng_cmd == CMD_NACK);
            advance_phase();
          end else if (eng_phase == 1) begin
            scl_lvl = 1'b1;
            advance_phase();
          end else begin
            scl_lvl = 1'b0;
            close_command();
          end
        end
        default: ;
      endcase
    end
  endtask

  // One tick of the bus engine: it takes a command only while idle, otherwise it counts down
  // the current delay step and acts when the step runs out.
  task automatic predict_bus_tick(input bus_tick_t t, output bus_state_t s);
    done_flag = 1'b0;
    if (eng_cmd == CMD_IDLE) begin
      if (t.kind != CMD_IDLE) begin
        eng_cmd = t.kind;
        eng_phase = '0;
        bits_done = '0;
        step_left = '0;
        if (t.kind == CMD_SEND) shifter = t.tx;
        if (t.kind == CMD_READ) begin
          shifter = '0;
          sda_lvl = 1'b1;
          read_acks = t.ack_sel;
        end
        if (t.kind == CMD_WACK) begin
          poll_count = '0;
          timeout_flag = 1'b0;
        end
        run_bus_phase(t.sda);
      end
    end else if (step_left > 1) begin
      step_left--;
    end else begin
      run_bus_phase(t.sda);
    end
    s.scl = scl_lvl;
    s.sda_rel = sda_lvl;
    s.busy = (eng_cmd != CMD_IDLE);
    s.done = done_flag;
    s.rx = rx_latched;
    s.err = timeout_flag;
  endtask

  // Every tick is accepted in order and yields exactly one result, so the expected state is
  // worked out as the tick is queued.
  task automatic push_tick(input cmd_e kind, input logic [7:0] tx, input logic ack_sel,
                           input logic sda);
    bus_tick_t  t;
    bus_state_t s;
    while (pending_ticks.size() >= QUEUE_CAP) @(negedge clk_i);
    t.kind = kind;
    t.tx = tx;
    t.ack_sel = ack_sel;
    t.sda = sda;
    predict_bus_tick(t, s);
    pending_ticks.push_back(t);
    expected_bus_states.push_back(s);
  endtask

  // Queues a command and then plain ticks until the engine is idle again. Now and then a
  // busy tick carries a command of its own, which the engine must ignore.
  task automatic issue(input cmd_e kind, input logic [7:0] tx, input logic ack_sel,
                       input sda_style_e style);
    cmd_e noise;
    if (eng_cmd == CMD_IDLE && kind != CMD_IDLE) commands_started++;
    push_tick(kind, tx, ack_sel, pick_sda(style));
    while (eng_cmd != CMD_IDLE) begin
      noise = ($urandom_range(0, 7) == 0) ? cmd_e'($urandom_range(0, 7)) : CMD_IDLE;
      push_tick(noise, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), pick_sda(style));
    end
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    @(posedge clk_i);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid <= 1'b0;
    if (idx == CFG_HALF_PERIOD) half_period = data;
    else if (idx == CFG_ACK_LIMIT) ack_limit = data[7:0];
  endtask

  // The ack limit register is 8 bits wide, so the upper data bits get random filler.
  task automatic write_timing(input logic [15:0] hp, input logic [7:0] limit);
    write_reg(CFG_HALF_PERIOD, hp);
    write_reg(CFG_ACK_LIMIT, {8'($urandom_range(0, 255)), limit});
  endtask

  // Waits until every queued tick went in and every result came out, then lets the pipeline
  // settle before anything else happens.
  task automatic drain();
    while (pending_ticks.size() != 0 || in_valid || expected_bus_states.size() != 0)
      @(negedge clk_i);
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  // A well-formed bus transfer: start, address byte and ack, then a few bytes written or
  // read, then a stop, or a repeated start if the next transfer follows straight on.
  task automatic random_transfer();
    int unsigned nbytes;
    bit          reading;
    logic        ack_sel;
    issue(CMD_START, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), SDA_NOISE);
    issue(CMD_SEND, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), SDA_NOISE);
    issue(CMD_WACK, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), pick_ack_style());
    if (timeout_flag) return;
    reading = 1'($urandom_range(0, 1));
    nbytes = $urandom_range(1, 3);
    for (int unsigned i = 0; i < nbytes; i++) begin
      if (reading) begin
        ack_sel = (i + 1 < nbytes);
        if ($urandom_range(0, 4) == 0) ack_sel = ~ack_sel;
        issue(CMD_READ, 8'($urandom_range(0, 255)), ack_sel, SDA_NOISE);
      end else begin
        issue(CMD_SEND, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), SDA_NOISE);
        issue(CMD_WACK, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
              pick_ack_style());
        if (timeout_flag) return;
      end
    end
    if ($urandom_range(0, 4) != 0)
      issue(CMD_STOP, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), SDA_NOISE);
  endtask

  // One configuration setting and a batch of random traffic under it. Most of the traffic is
  // well-formed transfers; the rest is single commands of any kind, including ack and nack
  // alone, and idle ticks between commands.
  task automatic random_phase(input logic [15:0] hp, input logic [7:0] limit,
                              input int unsigned n_cmds);
    int unsigned goal;
    goal = commands_started + n_cmds;
    write_timing(hp, limit);
    while (commands_started < goal) begin
      if ($urandom_range(0, 9) < 8) begin
        random_transfer();
      end else begin
        issue(cmd_e'($urandom_range(1, 7)), 8'($urandom_range(0, 255)),
              1'($urandom_range(0, 1)), sda_style_e'($urandom_range(0, 3)));
      end
      repeat ($urandom_range(0, 3))
        push_tick(CMD_IDLE, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                  1'($urandom_range(0, 1)));
    end
    drain();
  endtask

  // Input driver. A new tick is put on the bus only when the previous one was taken (or none
  // was up), so valid never drops while a transfer is pending.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (!in_valid || in_ready_o) begin
        if (send_wait > 0) begin
          send_wait--;
          in_valid <= 1'b0;
        end else if (pending_ticks.size() > 0) begin
          next_tick = pending_ticks.pop_front();
          kind_i <= next_tick.kind;
          tx_byte_i <= next_tick.tx;
          ack_after_read_i <= next_tick.ack_sel;
          sda_in_i <= next_tick.sda;
          in_valid <= 1'b1;
          send_wait = pick_gap(send_calm);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Output monitor. Each result transfer is checked against the oldest expected bus state,
  // field by field, and the ready line stalls at random.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && out_ready) begin
        if (expected_bus_states.size() == 0) begin
          $error("result transfer with no tick waiting for it");
          fault_count++;
        end else begin
          want = expected_bus_states.pop_front();
          if (scl_out_o !== want.scl) begin
            $error("scl_out: expected %0d, got %0d", want.scl, scl_out_o);
            fault_count++;
          end
          if (sda_release_o !== want.sda_rel) begin
            $error("sda_release: expected %0d, got %0d", want.sda_rel, sda_release_o);
            fault_count++;
          end
          if (busy_res_o !== want.busy) begin
            $error("busy_res: expected %0d, got %0d", want.busy, busy_res_o);
            fault_count++;
          end
          if (done_res_o !== want.done) begin
            $error("done_res: expected %0d, got %0d", want.done, done_res_o);
            fault_count++;
          end
          if (rx_byte_o !== want.rx) begin
            $error("rx_byte: expected %02h, got %02h", want.rx, rx_byte_o);
            fault_count++;
          end
          if (ack_error_o !== want.err) begin
            $error("ack_error: expected %0d, got %0d", want.err, ack_error_o);
            fault_count++;
          end
        end
      end
      if (recv_wait > 0) begin
        recv_wait--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
        recv_wait = pick_gap(recv_calm);
      end
    end
  end

  // Watchdog. A missing result or a hung handshake shows up as a long run of cycles without
  // any transfer on any of the three channels.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid && in_ready_o) || (out_valid_o && out_ready) || (cfg_valid && cfg_ready_o))
      begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
        if (quiet_cycles >= QUIET_LIMIT) begin
          $display("RESULT: ERROR");
          $finish;
        end
      end
    end
  end

  initial begin
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Reset value of the half period: a start at 160 ticks per step.
    issue(CMD_START, 8'h00, 1'b0, SDA_NOISE);
    drain();

    // Reset value of the ack limit: with one-tick steps, an ack wait that never sees the
    // slave needs all 250 tolerated polls before it times out into a stop.
    write_reg(CFG_HALF_PERIOD, 16'd0);
    issue(CMD_WACK, 8'hFF, 1'b1, SDA_STUCK_HIGH);
    drain();

    // Writes to indexes outside the map must change nothing. Then zero half period, where
    // each step lasts one tick, and zero ack limit, where the first high poll times out.
    write_reg(CFG_SPARE_LO, 16'($urandom_range(0, 65535)));
    write_reg(CFG_SPARE_HI, 16'($urandom_range(0, 65535)));
    write_timing(16'd0, 8'd0);
    issue(CMD_START, 8'h00, 1'b0, SDA_NOISE);
    issue(CMD_SEND, 8'h00, 1'b0, SDA_NOISE);
    issue(CMD_SEND, 8'hFF, 1'b1, SDA_NOISE);
    issue(CMD_WACK, 8'h00, 1'b0, SDA_LOW);
    issue(CMD_WACK, 8'h00, 1'b0, SDA_STUCK_HIGH);
    issue(CMD_START, 8'h00, 1'b0, SDA_NOISE);
    issue(CMD_SEND, 8'hA5, 1'b0, SDA_NOISE);
    issue(CMD_READ, 8'h00, 1'b1, SDA_NOISE);
    issue(CMD_READ, 8'hFF, 1'b0, SDA_NOISE);
    issue(CMD_ACK, 8'h00, 1'b0, SDA_NOISE);
    issue(CMD_NACK, 8'h00, 1'b1, SDA_NOISE);
    // Commands that arrive while a send is running are only ticks.
    push_tick(CMD_SEND, 8'h3C, 1'b0, 1'b1);
    push_tick(CMD_START, 8'hC3, 1'b1, 1'b0);
    push_tick(CMD_READ, 8'h00, 1'b1, 1'b1);
    issue(CMD_IDLE, 8'h00, 1'b0, SDA_NOISE);
    issue(CMD_STOP, 8'h00, 1'b0, SDA_NOISE);
    drain();

    // One-tick steps with a limit of one poll: one high poll is tolerated, two are not.
    write_timing(16'd1, 8'd1);
    issue(CMD_START, 8'h00, 1'b0, SDA_NOISE);
    issue(CMD_SEND, 8'h5A, 1'b0, SDA_NOISE);
    issue(CMD_WACK, 8'h00, 1'b0, SDA_ACK_SOON);
    issue(CMD_WACK, 8'h00, 1'b0, SDA_STUCK_HIGH);
    issue(CMD_STOP, 8'h00, 1'b0, SDA_NOISE);
    drain();

    random_phase(16'd1, 8'd2, 4);
    random_phase(16'd0, 8'd5, 4);

    if (fault_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// File: i2c_bit_bang_master.f
hw/rtl/i2cbb_pkg.sv
hw/rtl/i2cbb_front.sv
hw/rtl/i2cbb_engine.sv
hw/rtl/i2c_bit_bang_master.sv
bench/tb_i2c_bit_bang_master.sv
